/* rtl/core/srse_pkg.sv */
// ----------------------------------------------------------------------------
// srse_pkg
// Shared constants for the sorted range set engine.
// ----------------------------------------------------------------------------
package srse_pkg;

  localparam int MAX_RANGES = 64;
  localparam int VALUE_BITS = 21;
  localparam int IDX_W      = $clog2(MAX_RANGES);
  localparam int CNT_W      = $clog2(MAX_RANGES + 1);
  localparam int SUM_W      = VALUE_BITS + 1;
  localparam int ENTRY_W    = 2 * VALUE_BITS;

  localparam logic [2:0] FUNC_ADD   = 3'd0;
  localparam logic [2:0] FUNC_SUB   = 3'd1;
  localparam logic [2:0] FUNC_TEST  = 3'd2;
  localparam logic [2:0] FUNC_CLEAR = 3'd3;
  localparam logic [2:0] FUNC_COUNT = 3'd4;

endpackage

/* rtl/core/srse_ram.sv */
// ----------------------------------------------------------------------------
// srse_ram
// Simple dual-port RAM, one write port, one registered read port.
// ----------------------------------------------------------------------------
module srse_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16,
  parameter int AW    = $clog2(DEPTH)
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

/* rtl/core/sorted_range_set_engine.sv */
// ----------------------------------------------------------------------------
// sorted_range_set_engine
// Set of code points kept as a sorted table of disjoint inclusive ranges.
// ----------------------------------------------------------------------------
// One operation at a time: pulse start while busy is low. The result beat
// appears on the result ports for exactly one cycle with done high; the
// receiver cannot stall it. Add and subtract stream the current table out of
// one RAM bank and write the rebuilt table into the other bank, flipping
// banks when the result fits (otherwise status reports full and the table
// stays). Each stored range takes a RAM read state and a process state; a
// range that splits, or the point where the new merged range lands, takes
// one more process state. Test and count walk the table the same way; clear
// and unused codes go straight to the finish state. No clearing pass: reset
// empties the table through the range count alone.
// ----------------------------------------------------------------------------
module sorted_range_set_engine (
  input  logic        clk,
  input  logic        rst,
  input  logic        cfg_write,
  input  logic        cfg_data,
  input  logic        start,
  input  logic [2:0]  func,
  input  logic [20:0] range_first,
  input  logic [20:0] range_last,
  output logic        busy,
  output logic        done,
  output logic        is_member,
  output logic [21:0] total_members,
  output logic [6:0]  stored_ranges,
  output logic        status
);

  localparam int VB = srse_pkg::VALUE_BITS;
  localparam int IW = srse_pkg::IDX_W;
  localparam int CW = srse_pkg::CNT_W;
  localparam int SW = srse_pkg::SUM_W;
  localparam int EW = srse_pkg::ENTRY_W;

  typedef enum logic [1:0] {S_IDLE, S_RD, S_PROC, S_FIN} state_t;

  state_t        state;
  logic          bank;         // bank holding the live table
  logic          invert_set;
  logic [CW-1:0] total;
  logic [2:0]    op;
  logic [VB-1:0] lo, hi, tv;
  logic [CW-1:0] rd_idx;
  logic [CW-1:0] n;            // entries written into the new table
  logic          merged, sub, full, member;
  logic [VB-1:0] ns, ne;
  logic [SW-1:0] acc;

  // RAM ports
  logic [EW-1:0] rdata_a, rdata_b, rdata, wdata;
  logic          wr_req, we;
  logic [VB-1:0] rs, re, wr_s, wr_e;

  assign rdata = bank ? rdata_b : rdata_a;
  assign rs    = rdata[EW-1:VB];
  assign re    = rdata[VB-1:0];
  assign wdata = {wr_s, wr_e};
  assign we    = wr_req && (n < CW'(srse_pkg::MAX_RANGES));

  srse_ram #(.WIDTH(EW), .DEPTH(srse_pkg::MAX_RANGES)) u_ram_a (
    .clk   (clk),
    .we    (we && bank),
    .waddr (n[IW-1:0]),
    .wdata (wdata),
    .raddr (rd_idx[IW-1:0]),
    .rdata (rdata_a)
  );

  srse_ram #(.WIDTH(EW), .DEPTH(srse_pkg::MAX_RANGES)) u_ram_b (
    .clk   (clk),
    .we    (we && !bank),
    .waddr (n[IW-1:0]),
    .wdata (wdata),
    .raddr (rd_idx[IW-1:0]),
    .rdata (rdata_b)
  );

  // effective operation after inversion
  logic ins, rem;
  assign ins = (op == srse_pkg::FUNC_ADD && !invert_set) ||
               (op == srse_pkg::FUNC_SUB && invert_set);
  assign rem = (op == srse_pkg::FUNC_SUB && !invert_set) ||
               (op == srse_pkg::FUNC_ADD && invert_set);

  // one extra bit on compares so end+1 never wraps
  logic [VB:0] s_x, e_x, lo_x, hi_x, tv_x;
  assign s_x  = {1'b0, rs};
  assign e_x  = {1'b0, re};
  assign lo_x = {1'b0, lo};
  assign hi_x = {1'b0, hi};
  assign tv_x = {1'b0, tv};

  logic adv, merge_upd, merged_set, sub_set, sub_clr, mem_hit;

  always_comb begin
    wr_req     = 1'b0;
    wr_s       = rs;
    wr_e       = re;
    adv        = 1'b0;
    merge_upd  = 1'b0;
    merged_set = 1'b0;
    sub_set    = 1'b0;
    sub_clr    = 1'b0;
    mem_hit    = 1'b0;
    if (state == S_PROC) begin
      if (ins) begin
        if (merged) begin
          wr_req = 1'b1;
          adv    = 1'b1;
        end else if (e_x + 1'b1 < lo_x) begin
          wr_req = 1'b1;
          adv    = 1'b1;
        end else if (s_x <= hi_x + 1'b1) begin
          merge_upd = 1'b1;
          adv       = 1'b1;
        end else begin
          // first range past the new one: place the merged range first
          wr_req     = 1'b1;
          wr_s       = ns;
          wr_e       = ne;
          merged_set = 1'b1;
        end
      end else if (rem) begin
        if (e_x < lo_x || s_x > hi_x) begin
          wr_req = 1'b1;
          adv    = 1'b1;
        end else if (sub) begin
          wr_req  = 1'b1;
          wr_s    = hi + 1'b1;
          sub_clr = 1'b1;
          adv     = 1'b1;
        end else if (s_x < lo_x && e_x > hi_x) begin
          // split: low piece now, high piece next cycle
          wr_req  = 1'b1;
          wr_e    = lo - 1'b1;
          sub_set = 1'b1;
        end else if (s_x < lo_x) begin
          wr_req = 1'b1;
          wr_e   = lo - 1'b1;
          adv    = 1'b1;
        end else if (e_x > hi_x) begin
          wr_req = 1'b1;
          wr_s   = hi + 1'b1;
          adv    = 1'b1;
        end else begin
          adv = 1'b1;
        end
      end else begin
        mem_hit = (s_x <= tv_x) && (tv_x <= e_x);
        adv     = 1'b1;
      end
    end else if (state == S_FIN && ins && !merged) begin
      wr_req = 1'b1;
      wr_s   = ns;
      wr_e   = ne;
    end
  end

  logic          full_next;
  logic [CW-1:0] total_next;
  logic          apply;

  assign full_next  = full || (wr_req && !we);
  assign apply      = (ins || rem) && !full_next;
  assign total_next = (op == srse_pkg::FUNC_CLEAR) ? '0 :
                      apply ? (we ? n + 1'b1 : n) : total;

  assign busy = (state != S_IDLE);

  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= S_IDLE;
      bank       <= 1'b0;
      invert_set <= 1'b0;
      total      <= '0;
      done       <= 1'b0;
    end else begin
      done <= 1'b0;
      if (cfg_write) begin
        invert_set <= cfg_data;
      end
      case (state)
        S_IDLE: begin
          if (start) begin
            op     <= func;
            tv     <= range_first;
            lo     <= (range_first > range_last) ? range_last : range_first;
            hi     <= (range_first > range_last) ? range_first : range_last;
            ns     <= (range_first > range_last) ? range_last : range_first;
            ne     <= (range_first > range_last) ? range_first : range_last;
            rd_idx <= '0;
            n      <= '0;
            merged <= 1'b0;
            sub    <= 1'b0;
            full   <= 1'b0;
            member <= 1'b0;
            acc    <= '0;
            if (func == srse_pkg::FUNC_ADD || func == srse_pkg::FUNC_SUB ||
                func == srse_pkg::FUNC_TEST || func == srse_pkg::FUNC_COUNT) begin
              state <= S_RD;
            end else begin
              state <= S_FIN;
            end
          end
        end
        S_RD: begin
          state <= (rd_idx == total) ? S_FIN : S_PROC;
        end
        S_PROC: begin
          if (we) n <= n + 1'b1;
          full <= full_next;
          if (merge_upd) begin
            if (rs < ns) ns <= rs;
            if (re > ne) ne <= re;
          end
          if (merged_set) merged <= 1'b1;
          if (sub_set) sub <= 1'b1;
          if (sub_clr) sub <= 1'b0;
          if (mem_hit) member <= 1'b1;
          if (op == srse_pkg::FUNC_COUNT) begin
            acc <= acc + SW'(re - rs) + 1'b1;
          end
          if (adv) begin
            rd_idx <= rd_idx + 1'b1;
            state  <= S_RD;
          end
        end
        S_FIN: begin
          done          <= 1'b1;
          total         <= total_next;
          stored_ranges <= total_next;
          status        <= (ins || rem) && full_next;
          is_member     <= (op == srse_pkg::FUNC_TEST) ? (member ^ invert_set) : 1'b0;
          total_members <= (op == srse_pkg::FUNC_COUNT) ? acc : '0;
          if (apply) bank <= !bank;
          state <= S_IDLE;
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  // never write past the table
  assert property (@(posedge clk) disable iff (rst) we |-> n < CW'(srse_pkg::MAX_RANGES))
    else $error("write beyond table");

  assert property (@(posedge clk) disable iff (rst) total <= CW'(srse_pkg::MAX_RANGES))
    else $error("range count out of bounds");

  assert property (@(posedge clk) disable iff (rst) done |-> $past(state == S_FIN))
    else $error("result beat without finish");

  assert property (@(posedge clk) disable iff (rst)
                   (done && status) |-> $stable(bank))
    else $error("table changed on full");

endmodule
